/* hdl/rsw_pkg.sv */
// ----------------------------------------------------------------------------
// rsw_pkg: shared types and constants for the redundant send window
// Field widths, result kind codes, command codes and the control/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rsw_pkg;

    localparam int TS_W   = 64;
    localparam int SEQ_W  = 31;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int KIND_W = 3;

    // stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 144;

    // per-packet limit register
    localparam logic [CNT_W-1:0] LIMIT_MIN   = 7'd1;
    localparam logic [CNT_W-1:0] LIMIT_MAX   = 7'd64;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

    // input command codes
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    // result kind codes
    localparam logic [KIND_W-1:0] KIND_ENTRY   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STALE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INCONS  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the input beat
        logic eval;         // apply the event to the window state
        logic rd;           // read ring at the read pointer
        logic load_entry;   // load one run entry into the output register
        logic load_single;  // load the single status result
    } rsw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic single;       // event yields one status result only
        logic entry_last;   // current run entry is the final one
        logic out_free;     // output register can take a beat this cycle
    } rsw_stat_t;

endpackage

/* hdl/rsw_ctrl.sv */
// ----------------------------------------------------------------------------
// rsw_ctrl: sequencing state machine
// Steps each event through capture, evaluate, ring read and result emission.
// ----------------------------------------------------------------------------
module rsw_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsw_pkg::rsw_stat_t stat,
    output rsw_pkg::rsw_cmd_t  cmd
);
    import rsw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.single ? ST_ONE : ST_START;
            end
            ST_START:
            begin
                // prefetch first entry
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_entry = 1'b1;
                    if (stat.entry_last)
                        state_next = ST_IDLE;
                    else
                        cmd.rd = 1'b1;
                end
            end
            ST_ONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hdl/rsw_datapath.sv */
// ----------------------------------------------------------------------------
// rsw_datapath: window state, entry ring and output register
// Holds sequence state, the ring of unacked timestamps and the result beat.
// ----------------------------------------------------------------------------
module rsw_datapath #(
    parameter int RING_DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rsw_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic [rsw_pkg::S_TDATA_W-1:0]  in_data,
    input  logic                           in_cmd,
    input  rsw_pkg::rsw_cmd_t              cmd,
    output rsw_pkg::rsw_stat_t             stat,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [rsw_pkg::M_TDATA_W-1:0]  out_data,
    output logic [rsw_pkg::KIND_W-1:0]     out_kind,
    output logic                           out_last
);
    import rsw_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = AW + 1;
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(RING_DEPTH);
    localparam logic [CW-1:0]    DEPTH_C  = CW'(RING_DEPTH);
    localparam logic [AW-1:0]    LAST_PTR = AW'(RING_DEPTH - 1);

    // captured event
    logic              ev_cmd_reg;
    logic [TS_W-1:0]   ev_ts_reg;
    logic [SEQ_W-1:0]  ev_pseq_reg;
    logic [SEQ_W-1:0]  ev_pack_reg;

    // window state
    logic [CNT_W-1:0]  limit_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  peer_seq_reg;

    // run state
    logic [AW-1:0]     rptr_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              ovf_reg;

    // ring
    logic [TS_W-1:0]   ring_mem [RING_DEPTH];
    logic [TS_W-1:0]   rd_data_reg;

    // output beat
    logic              o_valid_reg;
    logic [KIND_W-1:0] o_kind_reg;
    logic [SEQ_W-1:0]  o_seq_reg;
    logic [SEQ_W-1:0]  o_ack_reg;
    logic [CNT_W-1:0]  o_cnt_reg;
    logic [IDX_W-1:0]  o_idx_reg;
    logic [TS_W-1:0]   o_val_reg;
    logic              o_ovf_reg;
    logic              o_last_reg;

    // evaluate-cycle terms
    logic              full;
    logic [SUM_W-1:0]  tail_sum;
    logic [AW-1:0]     tail;
    logic [CW-1:0]     count_new;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  len_send;
    logic              stale;
    logic [SEQ_W-1:0]  unack_full;
    logic              incons;
    logic [CW-1:0]     drop;
    logic [SUM_W-1:0]  head_sum;
    logic [AW-1:0]     head_adv;
    logic [AW-1:0]     rptr_inc;
    logic              ring_wr;

    always_comb
    begin
        full      = (count_reg == DEPTH_C);
        tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
        tail      = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
        count_new = full ? count_reg : count_reg + CW'(1);

        if (limit_reg < LIMIT_MIN)
            lim = LIMIT_MIN;
        else if (limit_reg > LIMIT_MAX)
            lim = LIMIT_MAX;
        else
            lim = limit_reg;
        len_send = (CNT_W'(count_new) < lim) ? CNT_W'(count_new) : lim;

        stale      = (ev_pseq_reg < peer_seq_reg);
        unack_full = seq_reg - ev_pack_reg;
        incons     = (ev_pack_reg > seq_reg) || (unack_full > SEQ_W'(count_reg));
        drop       = count_reg - CW'(unack_full);
        head_sum   = SUM_W'(head_reg) + SUM_W'(drop);
        head_adv   = (head_sum >= DEPTH_S) ? AW'(head_sum - DEPTH_S) : AW'(head_sum);
        rptr_inc   = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + AW'(1);

        ring_wr    = cmd.eval && (ev_cmd_reg == CMD_SEND) && !full;
    end

    assign stat.single     = (ev_cmd_reg == CMD_ACK) && (stale || incons || (drop == '0));
    assign stat.entry_last = ((idx_reg + CNT_W'(1)) == len_reg);
    assign stat.out_free   = !o_valid_reg || out_ready;

    // event capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_cmd_reg  <= in_cmd;
            ev_ts_reg   <= in_data[63:0];
            ev_pseq_reg <= in_data[94:64];
            ev_pack_reg <= in_data[125:95];
        end
    end

    // config and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            head_reg     <= '0;
            count_reg    <= '0;
            seq_reg      <= '0;
            peer_seq_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (cmd.eval)
            begin
                if (ev_cmd_reg == CMD_SEND)
                begin
                    seq_reg   <= seq_reg + SEQ_W'(1);
                    count_reg <= count_new;
                end
                else if (!stale)
                begin
                    peer_seq_reg <= ev_pseq_reg;
                    if (!incons)
                    begin
                        head_reg  <= head_adv;
                        count_reg <= count_reg - drop;
                    end
                end
            end
        end
    end

    // run bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg <= '0;
            idx_reg  <= '0;
            len_reg  <= '0;
            kind_reg <= KIND_ENTRY;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                rptr_reg <= head_reg;   // run starts at the old head
                idx_reg  <= '0;
                if (ev_cmd_reg == CMD_SEND)
                begin
                    kind_reg <= KIND_ENTRY;
                    len_reg  <= len_send;
                    ovf_reg  <= full;
                end
                else
                begin
                    ovf_reg <= 1'b0;
                    len_reg <= CNT_W'(drop);
                    if (stale)
                        kind_reg <= KIND_STALE;
                    else if (incons)
                        kind_reg <= KIND_INCONS;
                    else if (drop == '0)
                        kind_reg <= KIND_NONE;
                    else
                        kind_reg <= KIND_RELEASE;
                end
            end
            else
            begin
                if (cmd.rd)
                    rptr_reg <= rptr_inc;
                if (cmd.load_entry)
                    idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (ring_wr)
            ring_mem[tail] <= ev_ts_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            rd_data_reg <= ring_mem[rptr_reg];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (cmd.load_entry || cmd.load_single)
            o_valid_reg <= 1'b1;
        else if (out_ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            o_kind_reg <= kind_reg;
            o_seq_reg  <= seq_reg;
            o_ack_reg  <= peer_seq_reg;
            o_cnt_reg  <= len_reg;
            o_idx_reg  <= idx_reg[IDX_W-1:0];
            o_val_reg  <= (kind_reg == KIND_ENTRY) ? rd_data_reg : ev_ts_reg - rd_data_reg;
            o_ovf_reg  <= ovf_reg;
            o_last_reg <= stat.entry_last;
        end
        else if (cmd.load_single)
        begin
            o_kind_reg <= kind_reg;
            o_seq_reg  <= seq_reg;
            o_ack_reg  <= peer_seq_reg;
            o_cnt_reg  <= '0;
            o_idx_reg  <= '0;
            o_val_reg  <= '0;
            o_ovf_reg  <= 1'b0;
            o_last_reg <= 1'b1;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_kind  = o_kind_reg;
    assign out_last  = o_last_reg;
    assign out_data  = {4'b0, o_ovf_reg, o_val_reg, o_idx_reg, o_cnt_reg, o_ack_reg, o_seq_reg};

endmodule

/* hdl/redundant_send_window.sv */
// ----------------------------------------------------------------------------
// redundant_send_window: sender-side window for a redundant datagram scheme
// Sends append a timestamp while the ring has room and emit the oldest buffered
// entries; acks release acknowledged entries from the head and report their delay.
// ----------------------------------------------------------------------------
// Sequence: capture, evaluate, ring read, then load into the output register;
//   a status-only result skips the ring read.
// Throughput: one result beat per cycle while the receiver does not stall, as
//   the single ring read port feeds one entry per beat; the input stays not
//   ready until the last result of an event is loaded.
// Reset: rst_n async active low; clears sequence state, ring pointers and
//   count, and sets the per-packet limit to 64. Ring contents are not cleared.
// ----------------------------------------------------------------------------
module redundant_send_window #(
    parameter int RING_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // per-packet limit register
    input  logic                          cfg_we,
    input  logic [rsw_pkg::CNT_W-1:0]     cfg_wdata,

    // event input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [63:0] time_stamp, [94:64] peer_seq, [125:95] peer_ack, [127:126] zero
    input  logic [rsw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic                          s_axis_tuser,

    // result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [30:0] seq_out, [61:31] ack_out, [68:62] entry_count,
    // [74:69] entry_index, [138:75] value, [139] overflow, [143:140] zero
    output logic [rsw_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] kind
    output logic [rsw_pkg::KIND_W-1:0]    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import rsw_pkg::*;

    rsw_cmd_t  dp_cmd;
    rsw_stat_t dp_stat;

    // Controller: one event at a time; ready only between events. The
    // output register lets the next beat be accepted while the final
    // result of the previous event still waits downstream.
    rsw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // Datapath: window state, timestamp ring, delay subtractor and the
    // result beat register.
    rsw_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_cmd    (s_axis_tuser),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

/* test/rsw_window_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsw_window_checker: scoreboard for the redundant send window
// Watches the limit register, the event stream and the result stream. Keeps
// its own copy of the window, predicts the result beats of every accepted
// event and compares each result beat field by field, oldest first.
// ----------------------------------------------------------------------------
module rsw_window_checker #(
    parameter int DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rsw_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [rsw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [rsw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic [rsw_pkg::KIND_W-1:0]     m_axis_tuser,
    input  logic                           m_axis_tlast,
    output int                             fails,
    output int                             checked,
    output int                             pending
);
    import rsw_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack;
        logic [CNT_W-1:0]  cnt;
        logic [IDX_W-1:0]  idx;
        logic [TS_W-1:0]   val;
        logic              ovf;
        logic              last;
    } win_beat_t;

    // model of the window
    logic [TS_W-1:0]  stamp_ring [0:DEPTH-1];
    int               head;
    int               held;
    logic [SEQ_W-1:0] loc_seq;
    logic [SEQ_W-1:0] peer_seq_r;
    logic [CNT_W-1:0] limit;

    win_beat_t        beats_due_q [$];

    // header fields always reflect the state after the event
    task automatic queue_beat(input logic [KIND_W-1:0] kind, input int cnt, input int idx,
                              input logic [TS_W-1:0] val, input logic ovf, input logic last);
        win_beat_t b;
        b.kind = kind;
        b.seq  = loc_seq;
        b.ack  = peer_seq_r;
        b.cnt  = cnt[CNT_W-1:0];
        b.idx  = idx[IDX_W-1:0];
        b.val  = val;
        b.ovf  = ovf;
        b.last = last;
        beats_due_q = {beats_due_q, b};
    endtask

    task automatic advance_window(input logic cmd, input logic [TS_W-1:0] ts,
                                  input logic [SEQ_W-1:0] pseq, input logic [SEQ_W-1:0] pack);
        int               lim;
        int               len;
        int               drop;
        logic             ovf;
        logic [SEQ_W-1:0] unacked;
        if (cmd == CMD_SEND)
        begin
            loc_seq = loc_seq + SEQ_W'(1);
            ovf     = 1'b0;
            if (held < DEPTH)
            begin
                stamp_ring[AW'((head + held) % DEPTH)] = ts;
                held++;
            end
            else
                ovf = 1'b1;
            // out-of-range limits are clamped, not rejected
            lim = int'(limit);
            if (lim < int'(LIMIT_MIN))
                lim = int'(LIMIT_MIN);
            if (lim > int'(LIMIT_MAX))
                lim = int'(LIMIT_MAX);
            len = (held < lim) ? held : lim;
            for (int i = 0; i < len; i++)
                queue_beat(KIND_ENTRY, len, i, stamp_ring[AW'((head + i) % DEPTH)], ovf,
                           i == len - 1);
        end
        else if (pseq < peer_seq_r)
            queue_beat(KIND_STALE, 0, 0, '0, 1'b0, 1'b1);
        else
        begin
            peer_seq_r = pseq;
            unacked    = loc_seq - pack;
            if (pack > loc_seq || int'(unacked) > held)
                queue_beat(KIND_INCONS, 0, 0, '0, 1'b0, 1'b1);
            else
            begin
                drop = held - int'(unacked);
                if (drop == 0)
                    queue_beat(KIND_NONE, 0, 0, '0, 1'b0, 1'b1);
                for (int i = 0; i < drop; i++)
                    queue_beat(KIND_RELEASE, drop, i,
                               ts - stamp_ring[AW'((head + i) % DEPTH)],
                               1'b0, i == drop - 1);
                head = (head + drop) % DEPTH;
                held = held - drop;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [TS_W-1:0] expv,
                                 input logic [TS_W-1:0] gotv);
        if (expv !== gotv)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, expv, gotv);
            fails++;
        end
    endtask

    task automatic check_result_beat();
        win_beat_t d;
        if (beats_due_q.size() == 0)
        begin
            $error("result beat with nothing expected: kind %0d", m_axis_tuser);
            fails++;
        end
        else
        begin
            d = beats_due_q.pop_front();
            compare_field("kind",        TS_W'(d.kind), TS_W'(m_axis_tuser));
            compare_field("seq_out",     TS_W'(d.seq),  TS_W'(m_axis_tdata[30:0]));
            compare_field("ack_out",     TS_W'(d.ack),  TS_W'(m_axis_tdata[61:31]));
            compare_field("entry_count", TS_W'(d.cnt),  TS_W'(m_axis_tdata[68:62]));
            compare_field("entry_index", TS_W'(d.idx),  TS_W'(m_axis_tdata[74:69]));
            compare_field("value",       d.val,         m_axis_tdata[138:75]);
            compare_field("overflow",    TS_W'(d.ovf),  TS_W'(m_axis_tdata[139]));
            compare_field("last",        TS_W'(d.last), TS_W'(m_axis_tlast));
            checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head       = 0;
            held       = 0;
            loc_seq    = '0;
            peer_seq_r = '0;
            limit      = LIMIT_RESET;
            beats_due_q.delete();
            fails      = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result_beat();
            if (cfg_we)
                limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                advance_window(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[94:64],
                               s_axis_tdata[125:95]);
            pending = beats_due_q.size();
        end
    end

endmodule

/* test/tb_redundant_send_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_redundant_send_window: stimulus and verdict for the redundant send window
// Drives send and ack events through the event stream with random gaps and
// receiver stalls, sweeps the per-packet limit, fills the ring past full and
// holds the result stream off long enough to back up the input. All result
// checking is done by rsw_window_checker.
// ----------------------------------------------------------------------------
module tb_redundant_send_window;

    import rsw_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 300000;   // far above the slowest legal run
    localparam int HOLD_CYCLES = 400;      // one long receiver hold-off
    localparam int GAP_PCT     = 18;       // idle percentage on either side
    localparam int SEQ_MAX     = 32'h7FFF_FFFF;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [63:0] time_stamp, [94:64] peer_seq, [125:95] peer_ack, [127:126] zero
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [0] cmd
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [30:0] seq_out, [61:31] ack_out, [68:62] entry_count,
    // [74:69] entry_index, [138:75] value, [139] overflow, [143:140] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [2:0] kind
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    int fails;
    int checked;
    int pending;

    // beat accepted on the event stream at the last rising edge
    logic in_fire = 1'b0;

    // both sides run without random gaps while calm is set; the hold-off still applies
    logic calm          = 1'b0;
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;

    // sender-side view of the protocol, used only to shape well-formed acks
    int          tx_seq   = 0;     // sends issued
    int          tx_acked = 0;     // highest consistent cumulative ack
    int          rx_peer  = 0;     // highest peer sequence not rejected as stale
    int          n_sends  = 0;
    int          n_acks   = 0;
    logic [63:0] now_us;

    redundant_send_window #(
        .RING_DEPTH (RING_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsw_window_checker #(
        .DEPTH (RING_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fails         (fails),
        .checked       (checked),
        .pending       (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        in_fire <= s_axis_tvalid && s_axis_tready;

    // Receiver: random stalls, none while calm, plus one long hold-off on request.
    // During the hold-off the sender keeps offering so the block fills and
    // pushes back on the event stream.
    initial
    begin
        int held_cycles;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
                    @(negedge clk);
            end
            else
                m_axis_tready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one event beat and return at the falling edge after it is taken.
    // Entered and left at a falling edge.
    task automatic offer_event(input logic cmd, input logic [63:0] ts,
                               input logic [30:0] pseq, input logic [30:0] pack);
        while (!calm && $urandom_range(0, 99) < GAP_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, pack, pseq, ts};
        @(negedge clk);
        while (!in_fire)
            @(negedge clk);
        if (cmd == CMD_SEND)
            n_sends++;
        else
            n_acks++;
    endtask

    // peer fields are don't-care on a send; fill them with noise anyway
    task automatic post_send(input logic [63:0] ts);
        offer_event(CMD_SEND, ts, 31'($urandom), 31'($urandom));
        tx_seq++;
    endtask

    task automatic post_ack(input int pseq, input int pack, input logic [63:0] now);
        offer_event(CMD_ACK, now, pseq[30:0], pack[30:0]);
        if (pseq >= rx_peer)
        begin
            rx_peer = pseq;
            // consistent only while no sample has been dropped for a full ring
            if (pack >= tx_acked && pack <= tx_seq)
                tx_acked = pack;
        end
    endtask

    // mostly a running microsecond clock, now and then any 64-bit value
    function automatic logic [63:0] pick_stamp();
        if ($urandom_range(0, 99) < 20)
            return {$urandom, $urandom};
        now_us = now_us + 64'($urandom_range(1, 500));
        return now_us;
    endfunction

    // Register writes only with the block drained; the extra cycles cover
    // the capture/evaluate pipeline.
    task automatic write_limit(input logic [CNT_W-1:0] lim);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int               r;
        int               noise;
        logic [CNT_W-1:0] lim;

        now_us = {$urandom, $urandom};
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed: limit at its reset value of 64 ----
        post_send(64'd0);
        post_send('1);
        post_send({$urandom, $urandom});
        post_ack(0, 0, pick_stamp());              // consistent, nothing released
        post_ack(0, 1, 64'd0);                     // release one, zero delay
        post_ack(0, SEQ_MAX, pick_stamp());        // ack ahead of local sequence
        post_ack(5, 3, 64'd5);                     // release two, delay wraps
        post_ack(2, 3, pick_stamp());              // stale peer sequence
        post_ack(5, 2, pick_stamp());              // ack older than the ring
        post_ack(5, 3, pick_stamp());              // repeat of current ack
        post_ack(6, 0, pick_stamp());              // ack zero with the ring empty
        post_send(64'd0);
        post_send('1);
        repeat (3) post_send(pick_stamp());
        post_ack(6, tx_seq, pick_stamp());         // release all five

        // ---- fill the ring: limit 0 acts as 1, receiver held off mid-way ----
        write_limit(7'd0);
        calm = 1'b1;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            post_send(pick_stamp());
            if (i == 8)
                hold_off_req = 1'b1;
        end
        // limit above range acts as 64; these sends find the ring full
        write_limit(7'd127);
        post_send(pick_stamp());
        post_send(pick_stamp());
        post_ack(rx_peer + 1, tx_seq, pick_stamp());   // releases all 64
        calm = 1'b0;

        // ---- random: well-formed traffic with some stale and broken acks ----
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       lim = LIMIT_MIN;
                1:       lim = CNT_W'($urandom_range(2, 63));
                2:       lim = LIMIT_MAX;
                default: lim = CNT_W'($urandom_range(0, 127));
            endcase
            write_limit(lim);
            for (int k = 0; k < 22; k++)
            begin
                // keep the ring short of full so acks stay predictable
                if (tx_seq - tx_acked >= 60)
                    r = 60;
                else
                    r = $urandom_range(0, 99);
                if (r < 55)
                    post_send(pick_stamp());
                else if (r < 85)
                    post_ack(rx_peer + $urandom_range(0, 2),
                             tx_acked + $urandom_range(0, tx_seq - tx_acked), pick_stamp());
                else
                begin
                    noise = $urandom_range(0, 2);
                    if ((noise == 0 && rx_peer == 0) || (noise == 2 && tx_acked == 0))
                        noise = 1;
                    case (noise)
                        0:       post_ack($urandom_range(0, rx_peer - 1), $urandom & SEQ_MAX,
                                          pick_stamp());
                        1:       post_ack(rx_peer + $urandom_range(0, 2),
                                          tx_seq + 1 + $urandom_range(0, SEQ_MAX - tx_seq - 1),
                                          pick_stamp());
                        default: post_ack(rx_peer + $urandom_range(0, 2),
                                          $urandom_range(0, tx_acked - 1), pick_stamp());
                    endcase
                end
            end
        end

        // ---- peer sequence at its top value; only a repeat of it escapes stale ----
        post_ack(SEQ_MAX, tx_acked, pick_stamp());
        post_ack(SEQ_MAX - 1, $urandom & SEQ_MAX, pick_stamp());
        post_send(pick_stamp());
        post_ack(SEQ_MAX, tx_seq, pick_stamp());

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("covered %0d events (%0d sends, %0d acks), %0d result beats checked,",
                 n_sends + n_acks, n_sends, n_acks, checked);
        $display("limits 0..127, a full ring with dropped samples and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
